FILE: src/assert_macros.svh
// Assertion macros used by the splice segment mapper datapath.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define SSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/ssm_pkg.sv
// Shared types and constants of the splice segment mapper.
// No dependencies.
package ssm_pkg;
    localparam int MaxSegments = 16;
    localparam int SegW = $clog2(MaxSegments);
    localparam int CntW = $clog2(MaxSegments + 1);
    localparam int FrameW = 31;
    localparam int SampleW = 47;

    localparam logic [1:0] FuncAppend = 2'd0;
    localparam logic [1:0] FuncLookup = 2'd1;
    localparam logic [1:0] FuncSplit = 2'd2;
    localparam logic [1:0] FuncClear = 2'd3;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StNoFrame = 2'd1;
    localparam logic [1:0] StFull = 2'd2;
    localparam logic [1:0] StOverflow = 2'd3;

    typedef enum logic [2:0] {
        t_idle_e, t_fetch_e, t_decide_e, t_scan_e, t_tail_e
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, read total
        logic decide;    // classify the request
        logic scan;      // examine one segment (read registered)
        logic tail;      // emit trailing blank
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;      // request finished after decide
        logic scan_end;  // last segment reached, or a lookup has found its segment
        logic need_tail;
    } t_stat;
endpackage

FILE: src/ssm_ctrl.sv
// Controller state machine of the splice segment mapper.
// Depends on ssm_pkg.
module ssm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ssm_pkg::t_stat   i_stat,
    output ssm_pkg::t_cmd    o_cmd
);
    ssm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ssm_pkg::t_idle_e;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssm_pkg::t_idle_e:   if (start) n_state = ssm_pkg::t_fetch_e;
            ssm_pkg::t_fetch_e:  n_state = ssm_pkg::t_decide_e;
            ssm_pkg::t_decide_e: n_state = i_stat.done ? ssm_pkg::t_idle_e : ssm_pkg::t_scan_e;
            ssm_pkg::t_scan_e: begin
                if (i_stat.scan_end)
                    n_state = i_stat.need_tail ? ssm_pkg::t_tail_e : ssm_pkg::t_idle_e;
            end
            ssm_pkg::t_tail_e:   n_state = ssm_pkg::t_idle_e;
            default:             n_state = ssm_pkg::t_idle_e;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy = (r_state != ssm_pkg::t_idle_e);
        unique case (r_state)
            ssm_pkg::t_idle_e:   o_cmd.load = start;
            ssm_pkg::t_fetch_e:  ;
            ssm_pkg::t_decide_e: o_cmd.decide = 1'b1;
            ssm_pkg::t_scan_e:   o_cmd.scan = 1'b1;
            ssm_pkg::t_tail_e:   o_cmd.tail = 1'b1;
            default:             ;
        endcase
    end
endmodule

FILE: src/ssm_datapath.sv
// Datapath of the splice segment mapper: boundary tables, request registers,
// per-segment run arithmetic and the result register. Depends on ssm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ssm_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssm_pkg::t_cmd        i_cmd,
    output ssm_pkg::t_stat       o_stat,
    input  logic [1:0]           i_func,
    input  logic signed [31:0]   i_frame_index,
    input  logic [30:0]          i_frames_to_add,
    input  logic [46:0]          i_samples_to_add,
    input  logic signed [47:0]   i_range_start,
    input  logic [31:0]          i_range_length,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic                 o_run_kind,
    output logic [3:0]           o_segment_index,
    output logic [46:0]          o_local_position,
    output logic [31:0]          o_run_samples,
    output logic [31:0]          o_buffer_offset,
    output logic                 o_last
);
    localparam int SegW = ssm_pkg::SegW;
    localparam int CntW = ssm_pkg::CntW;

    logic [ssm_pkg::FrameW-1:0]  r_fmem [ssm_pkg::MaxSegments];
    logic [ssm_pkg::SampleW-1:0] r_smem [ssm_pkg::MaxSegments];
    logic [CntW-1:0] r_count;

    logic [1:0]         r_func;
    logic signed [31:0] r_fidx;
    logic [30:0]        r_fadd;
    logic [46:0]        r_sadd;
    logic signed [48:0] r_s;     // range start, one bit headroom
    logic signed [48:0] r_e;     // range end
    logic [31:0]        r_len;
    logic [30:0]        r_ftot;
    logic [46:0]        r_stot;
    logic [SegW-1:0]    r_idx;
    logic [30:0]        r_flo;   // lower frame bound of segment r_idx
    logic [46:0]        r_slo;
    logic [30:0]        r_fhi;   // read data at r_idx
    logic [46:0]        r_shi;
    logic               r_found;
    logic               r_tail;
    logic signed [48:0] r_ms, r_me;

    // one-entry read port, registered; during a scan fetch the next entry
    logic [SegW-1:0] rd_addr;
    always_comb begin
        rd_addr = r_idx;
        if (i_cmd.load) rd_addr = SegW'(r_count - CntW'(1));
        else if (i_cmd.scan) rd_addr = r_idx + SegW'(1);
        else if (i_cmd.decide) rd_addr = r_idx;
    end

    logic scan_last_seg;
    assign scan_last_seg = ({1'b0, r_idx} == CntW'(r_count - CntW'(1)));

    logic signed [48:0] stot_s, lo_s, hi_s, a_s, b_s, t_end;
    assign stot_s = {2'b0, r_stot};
    assign lo_s = {2'b0, r_slo};
    assign hi_s = {2'b0, r_shi};
    assign a_s = (lo_s > r_ms) ? lo_s : r_ms;
    assign b_s = (hi_s < r_me) ? hi_s : r_me;
    assign t_end = r_e - stot_s;

    logic [31:0] fadd_tot;
    logic [47:0] sadd_tot;
    assign fadd_tot = {1'b0, r_ftot} + {1'b0, r_fadd};
    assign sadd_tot = {1'b0, r_stot} + {1'b0, r_sadd};

    logic empty, split_out, lk_bad;
    assign empty = (r_count == '0);
    assign split_out = (r_len == '0) || empty || (r_e <= 49'sd0) || (r_s >= stot_s);
    assign lk_bad = empty || r_fidx[31] || ({1'b0, r_fidx[30:0]} >= {1'b0, r_ftot});

    always_comb begin
        o_stat.done = 1'b1;
        if (r_func == ssm_pkg::FuncLookup) o_stat.done = lk_bad;
        else if (r_func == ssm_pkg::FuncSplit) o_stat.done = split_out;
        o_stat.scan_end = scan_last_seg || (r_func == ssm_pkg::FuncLookup && r_found);
        o_stat.need_tail = r_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cmd.load) begin
                r_func <= i_func;
                r_fidx <= i_frame_index;
                r_fadd <= i_frames_to_add;
                r_sadd <= i_samples_to_add;
                r_s <= 49'(i_range_start);
                r_e <= 49'(i_range_start) + 49'(i_range_length);
                r_len <= i_range_length;
            end
            // fetch cycle (also idle cycles with no command): totals arrive from the registered read
            if (!i_cmd.load && !i_cmd.decide && !i_cmd.scan && !i_cmd.tail && !o_valid) begin
                r_ftot <= empty ? '0 : r_fhi;
                r_stot <= empty ? '0 : r_shi;
                r_idx <= '0;
            end
            if (i_cmd.decide) begin
                r_flo <= '0; r_slo <= '0; r_found <= 1'b0;
                r_ms <= r_s[48] ? 49'sd0 : r_s;
                r_me <= (r_e > stot_s) ? stot_s : r_e;
                r_tail <= (r_func == ssm_pkg::FuncSplit) && (r_e > stot_s);
                o_status <= ssm_pkg::StOk; o_run_kind <= 1'b0; o_segment_index <= '0;
                o_local_position <= '0; o_run_samples <= '0; o_buffer_offset <= '0;
                o_last <= 1'b1;
                unique case (r_func)
                    ssm_pkg::FuncAppend: begin
                        o_valid <= 1'b1;
                        if (r_count == CntW'(ssm_pkg::MaxSegments)) o_status <= ssm_pkg::StFull;
                        else if (fadd_tot[31] || sadd_tot[47]) o_status <= ssm_pkg::StOverflow;
                        else begin
                            r_fmem[SegW'(r_count)] <= fadd_tot[30:0];
                            r_smem[SegW'(r_count)] <= sadd_tot[46:0];
                            r_count <= r_count + CntW'(1);
                            o_segment_index <= 4'(r_count);
                        end
                    end
                    ssm_pkg::FuncLookup: begin
                        if (lk_bad) begin
                            o_valid <= 1'b1; o_status <= ssm_pkg::StNoFrame;
                        end
                    end
                    ssm_pkg::FuncSplit: begin
                        if (split_out) begin
                            o_valid <= 1'b1; o_run_kind <= 1'b1; o_run_samples <= r_len;
                        end else if (r_s[48]) begin
                            o_valid <= 1'b1; o_run_kind <= 1'b1; o_last <= 1'b0;
                            o_run_samples <= 32'(-r_s);
                        end
                    end
                    ssm_pkg::FuncClear: begin
                        o_valid <= 1'b1; r_count <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan) begin
                r_idx <= r_idx + SegW'(1);
                r_flo <= r_fhi;
                r_slo <= r_shi;
                if (r_func == ssm_pkg::FuncLookup) begin
                    if (!r_found && ({1'b0, r_fhi} > {1'b0, r_fidx[30:0]})) begin
                        r_found <= 1'b1;
                        o_valid <= 1'b1; o_status <= ssm_pkg::StOk; o_run_kind <= 1'b0;
                        o_segment_index <= 4'(r_idx);
                        o_local_position <= 47'(r_fidx[30:0] - r_flo);
                        o_run_samples <= '0; o_buffer_offset <= '0; o_last <= 1'b1;
                    end
                end else if (b_s > a_s) begin
                    o_valid <= 1'b1; o_status <= ssm_pkg::StOk; o_run_kind <= 1'b0;
                    o_segment_index <= 4'(r_idx);
                    o_local_position <= 47'(a_s - lo_s);
                    o_run_samples <= 32'(b_s - a_s);
                    o_buffer_offset <= 32'(a_s - r_s);
                    // the run that reaches the clipped end is final unless a tail follows
                    o_last <= (b_s == r_me) && !r_tail;
                end
            end
            if (i_cmd.tail) begin
                o_valid <= 1'b1; o_status <= ssm_pkg::StOk; o_run_kind <= 1'b1;
                o_segment_index <= '0; o_local_position <= '0;
                o_run_samples <= 32'(t_end);
                o_buffer_offset <= 32'(stot_s - r_s);
                o_last <= 1'b1;
            end
        end
    end

    // shared read port, registered
    always_ff @(posedge i_clk) begin
        r_fhi <= r_fmem[rd_addr];
        r_shi <= r_smem[rd_addr];
    end

    `SSM_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1,
        r_count <= CntW'(ssm_pkg::MaxSegments))
    `SSM_ASSERT_NEXT(a_tail_valid, i_clk, i_rst_n, i_cmd.tail, o_valid && o_last)
    `SSM_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(i_cmd))
endmodule

FILE: src/splice_segment_mapper_top.sv
// Splice segment mapper: usage notes
// A request is taken when start is high and busy is low; its fields are
// captured that cycle. Results appear with o_valid high for a single cycle,
// at most one per cycle; o_last marks the final result of a request. The
// receiver cannot stall, so results are never held.
// Flow: append, clear, failed lookups and out-of-range range splits give their
// result after capture, table read and decide. Other lookups and range splits
// then scan the segment table one entry per cycle, limited by the single shared
// table read port; a range split scans every entry (and may add a trailing
// blank), a lookup stops once it has found its segment.
// One request is in flight at a time.
// Reset (i_rst_n low at a clock edge) empties the table and returns to idle;
// boundary entries are not cleared, as only entries below the count are used.
// Depends on ssm_pkg, ssm_ctrl and ssm_datapath.
module splice_segment_mapper_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_frame_index,
    input  logic [30:0]        i_frames_to_add,
    input  logic [46:0]        i_samples_to_add,
    input  logic signed [47:0] i_range_start,
    input  logic [31:0]        i_range_length,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic               o_run_kind,
    output logic [3:0]         o_segment_index,
    output logic [46:0]        o_local_position,
    output logic [31:0]        o_run_samples,
    output logic [31:0]        o_buffer_offset,
    output logic               o_last
);
    ssm_pkg::t_cmd  cmd;
    ssm_pkg::t_stat stat;

    ssm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    ssm_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_func(i_func), .i_frame_index(i_frame_index),
        .i_frames_to_add(i_frames_to_add), .i_samples_to_add(i_samples_to_add),
        .i_range_start(i_range_start), .i_range_length(i_range_length),
        .o_valid(o_valid), .o_status(o_status), .o_run_kind(o_run_kind),
        .o_segment_index(o_segment_index), .o_local_position(o_local_position),
        .o_run_samples(o_run_samples), .o_buffer_offset(o_buffer_offset),
        .o_last(o_last)
    );
endmodule
